[rtl/core/lz_window_decompressor_unit_defines.svh]
// Assertion macros for the LZ window decompressor.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef LZ_WINDOW_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ_WINDOW_DECOMPRESSOR_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define LZWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lzwd_pkg.sv]
// Shared constants, codes and types of the LZ window decompressor.
// No dependencies.
package lzwd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int HDR_W        = $clog2(HEADER_BYTES + 1);
    localparam int HIST_DEPTH   = 4096;
    localparam int POS_W        = $clog2(HIST_DEPTH);
    localparam int COUNT_W      = 24;
    localparam int CTRL_BITS    = 16;
    localparam int CTRL_W       = $clog2(CTRL_BITS + 1);
    localparam int LEN_W        = 5;
    localparam int OFF_HI_W     = 4;

    localparam logic [7:0]         STORED_FLAG = 8'h01;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // Fault codes carried with each result item
    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OFFSET    = 2'd1,
        FAULT_EARLY_END = 2'd2
    } t_fault;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/lzwd_if.sv]
// Valid/ready channels of the LZ window decompressor: compressed input, decoded output.
// Depends on lzwd_pkg.
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       block_last;

    modport source (output valid, output in_byte, output block_last, input ready);
    modport sink   (input valid, input in_byte, input block_last, output ready);
endinterface

interface lzwd_out_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    out_byte;
    logic                          has_data;
    logic                          run_last;
    logic                          block_end;
    logic [1:0]                    fault;
    logic [lzwd_pkg::COUNT_W-1:0]  out_total;

    modport source (output valid, output out_byte, output has_data, output run_last,
                    output block_end, output fault, output out_total, input ready);
    modport sink   (input valid, input out_byte, input has_data, input run_last,
                    input block_end, input fault, input out_total, output ready);
endinterface

[rtl/core/lz_window_decompressor_unit.sv]
// LZ window decompressor: header, control words, literals, matches over a 4 KiB history.
// Depends on lzwd_pkg, lzwd_if and lz_window_decompressor_unit_defines.svh.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------------
//  i_in    | in  | valid/ready           | in_byte, block_last
//  o_out   | out | valid/ready, out reg  | out_byte, has_data, run_last, block_end,
//          |     |                       | fault, out_total
//
// A good match copies 1..16 bytes: each copied byte is one history read followed by
// an emit that outputs it and writes it back through the single RAM port pair.
// Reset clears all control state; the history RAM is not cleared and needs no sweep.
// Input is held off while a copy runs or while the output register waits to be taken.
`include "lz_window_decompressor_unit_defines.svh"

module lz_window_decompressor_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lzwd_in_if.sink          i_in,
    lzwd_out_if.source       o_out
);
    import lzwd_pkg::*;

    // History RAM
    logic [7:0] r_hist [HIST_DEPTH];
    logic [7:0] r_rd_data;

    // Control and block state
    t_state               r_state, n_state;
    logic [HDR_W-1:0]     r_header_left, n_header_left;
    logic                 r_stored, n_stored;
    logic [CTRL_BITS-1:0] r_ctrl_word, n_ctrl_word;
    logic [CTRL_W-1:0]    r_ctrl_left, n_ctrl_left;
    logic                 r_ctrl_hi, n_ctrl_hi;
    logic                 r_pair2, n_pair2;
    logic [OFF_HI_W-1:0]  r_off_hi, n_off_hi;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [POS_W-1:0]     r_wp, n_wp;
    logic [COUNT_W-1:0]   r_count, n_count;

    // Copy engine
    logic [POS_W-1:0]     r_src, n_src;
    logic [LEN_W-1:0]     r_copy_left, n_copy_left;
    logic                 r_copy_last, n_copy_last;

    // Output register
    logic                 r_ov, n_ov;
    logic [7:0]           r_o_byte, n_o_byte;
    logic                 r_o_has, n_o_has;
    logic                 r_o_run, n_o_run;
    logic                 r_o_end, n_o_end;
    t_fault               r_o_fault, n_o_fault;
    logic [COUNT_W-1:0]   r_o_total, n_o_total;

    // Handshake and datapath controls
    logic                 slot_free;
    logic                 in_ready;
    logic                 in_acc;
    logic                 rd_en;
    logic                 emit;
    logic                 wr_en;
    logic [7:0]           wr_data;
    logic                 start_copy;
    logic                 restart;
    logic [COUNT_W-1:0]   count_inc;
    logic [POS_W-1:0]     offset;
    logic                 bad_offset;

    assign slot_free  = !r_ov || o_out.ready;
    assign in_acc     = i_in.valid && in_ready;
    assign count_inc  = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
    assign offset     = {r_off_hi, i_in.in_byte};
    assign bad_offset = (offset == '0) || ({{(COUNT_W-POS_W){1'b0}}, offset} > r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && start_copy) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit) begin
                    n_state = (r_copy_left == LEN_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs: input ready, history read, copy emit
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        emit     = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = slot_free;
            ST_READ: rd_en    = 1'b1;
            ST_EMIT: emit     = slot_free;
            default: in_ready = 1'b0;
        endcase
    end

    // Decode one input item or one copied byte
    always_comb begin
        n_header_left = r_header_left;
        n_stored      = r_stored;
        n_ctrl_word   = r_ctrl_word;
        n_ctrl_left   = r_ctrl_left;
        n_ctrl_hi     = r_ctrl_hi;
        n_pair2       = r_pair2;
        n_off_hi      = r_off_hi;
        n_len         = r_len;
        n_wp          = r_wp;
        n_count       = r_count;
        n_src         = r_src;
        n_copy_left   = r_copy_left;
        n_copy_last   = r_copy_last;
        n_ov          = r_ov && !o_out.ready;
        n_o_byte      = r_o_byte;
        n_o_has       = r_o_has;
        n_o_run       = r_o_run;
        n_o_end       = r_o_end;
        n_o_fault     = r_o_fault;
        n_o_total     = r_o_total;
        wr_en         = 1'b0;
        wr_data       = r_rd_data;
        start_copy    = 1'b0;
        restart       = 1'b0;

        if (in_acc) begin
            // Default result: one no-data item
            n_ov      = 1'b1;
            n_o_byte  = 8'h00;
            n_o_has   = 1'b0;
            n_o_run   = 1'b1;
            n_o_end   = i_in.block_last;
            n_o_fault = FAULT_NONE;
            n_o_total = r_count;
            restart   = i_in.block_last;

            priority if (r_header_left != '0) begin
                if (r_header_left == HDR_W'(HEADER_BYTES)) begin
                    n_stored = (i_in.in_byte == STORED_FLAG);
                end
                n_header_left = r_header_left - HDR_W'(1);
                if (i_in.block_last && (n_header_left != '0)) begin
                    n_o_fault = FAULT_EARLY_END;
                end
            end else if (r_stored) begin
                wr_en     = 1'b1;
                wr_data   = i_in.in_byte;
                n_wp      = r_wp + POS_W'(1);
                n_count   = count_inc;
                n_o_byte  = i_in.in_byte;
                n_o_has   = 1'b1;
                n_o_total = count_inc;
            end else if (r_ctrl_left == '0) begin
                // Control word arrives low byte first
                if (!r_ctrl_hi) begin
                    n_ctrl_word = {8'h00, i_in.in_byte};
                    n_ctrl_hi   = 1'b1;
                end else begin
                    n_ctrl_word = {i_in.in_byte, r_ctrl_word[7:0]};
                    n_ctrl_left = CTRL_W'(CTRL_BITS);
                    n_ctrl_hi   = 1'b0;
                end
                if (i_in.block_last) begin
                    n_o_fault = FAULT_EARLY_END;
                end
            end else if (r_ctrl_word[0]) begin
                if (!r_pair2) begin
                    n_off_hi = i_in.in_byte[7:4];
                    n_len    = LEN_W'(i_in.in_byte[3:0]) + LEN_W'(1);
                    n_pair2  = 1'b1;
                    if (i_in.block_last) begin
                        n_o_fault = FAULT_EARLY_END;
                    end
                end else begin
                    n_pair2     = 1'b0;
                    n_ctrl_word = r_ctrl_word >> 1;
                    n_ctrl_left = r_ctrl_left - CTRL_W'(1);
                    if (bad_offset) begin
                        n_o_fault = FAULT_OFFSET;
                    end else begin
                        // Hand over to the copy engine; it delivers the results
                        n_ov        = 1'b0;
                        restart     = 1'b0;
                        start_copy  = 1'b1;
                        n_src       = r_wp - offset;
                        n_copy_left = r_len;
                        n_copy_last = i_in.block_last;
                    end
                end
            end else begin
                // Literal
                n_ctrl_word = r_ctrl_word >> 1;
                n_ctrl_left = r_ctrl_left - CTRL_W'(1);
                wr_en       = 1'b1;
                wr_data     = i_in.in_byte;
                n_wp        = r_wp + POS_W'(1);
                n_count     = count_inc;
                n_o_byte    = i_in.in_byte;
                n_o_has     = 1'b1;
                n_o_total   = count_inc;
            end
        end else if (emit) begin
            // Emit one copied byte and write it back to history
            wr_en       = 1'b1;
            wr_data     = r_rd_data;
            n_wp        = r_wp + POS_W'(1);
            n_count     = count_inc;
            n_src       = r_src + POS_W'(1);
            n_copy_left = r_copy_left - LEN_W'(1);
            n_ov        = 1'b1;
            n_o_byte    = r_rd_data;
            n_o_has     = 1'b1;
            n_o_run     = (r_copy_left == LEN_W'(1));
            n_o_end     = (r_copy_left == LEN_W'(1)) && r_copy_last;
            n_o_fault   = FAULT_NONE;
            n_o_total   = count_inc;
            restart     = (r_copy_left == LEN_W'(1)) && r_copy_last;
        end

        // Return block state to its start values after the final item
        if (restart) begin
            n_header_left = HDR_W'(HEADER_BYTES);
            n_stored      = 1'b0;
            n_ctrl_word   = '0;
            n_ctrl_left   = '0;
            n_ctrl_hi     = 1'b0;
            n_pair2       = 1'b0;
            n_off_hi      = '0;
            n_len         = '0;
            n_wp          = '0;
            n_count       = '0;
        end
    end

    // History RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[r_wp] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[r_src];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_header_left <= HDR_W'(HEADER_BYTES);
            r_stored      <= 1'b0;
            r_ctrl_word   <= '0;
            r_ctrl_left   <= '0;
            r_ctrl_hi     <= 1'b0;
            r_pair2       <= 1'b0;
            r_off_hi      <= '0;
            r_len         <= '0;
            r_wp          <= '0;
            r_count       <= '0;
            r_copy_left   <= '0;
            r_copy_last   <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_header_left <= n_header_left;
            r_stored      <= n_stored;
            r_ctrl_word   <= n_ctrl_word;
            r_ctrl_left   <= n_ctrl_left;
            r_ctrl_hi     <= n_ctrl_hi;
            r_pair2       <= n_pair2;
            r_off_hi      <= n_off_hi;
            r_len         <= n_len;
            r_wp          <= n_wp;
            r_count       <= n_count;
            r_copy_left   <= n_copy_left;
            r_copy_last   <= n_copy_last;
            r_ov          <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_o_byte  <= n_o_byte;
        r_o_has   <= n_o_has;
        r_o_run   <= n_o_run;
        r_o_end   <= n_o_end;
        r_o_fault <= n_o_fault;
        r_o_total <= n_o_total;
    end

    // Drive the channels
    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_ov;
    assign o_out.out_byte  = r_o_byte;
    assign o_out.has_data  = r_o_has;
    assign o_out.run_last  = r_o_run;
    assign o_out.block_end = r_o_end;
    assign o_out.fault     = r_o_fault;
    assign o_out.out_total = r_o_total;

    // Checks
    `LZWD_ASSERT_NOW(a_copy_has_work, r_state != ST_IDLE, r_copy_left != '0, "copy engine busy with nothing left")
    `LZWD_ASSERT_NEXT(a_read_then_emit, r_state == ST_READ, r_state == ST_EMIT, "history read not followed by emit")
    `LZWD_ASSERT_NEXT(a_copy_done_idle, emit && (r_copy_left == LEN_W'(1)), r_state == ST_IDLE, "copy did not finish")
    `LZWD_ASSERT_NOW(a_nodata_zero, r_ov && !r_o_has, r_o_byte == 8'h00, "no-data item carries a byte")

endmodule

[dv/lzwd_decode_checker.sv]
// Decode checker for the LZ window decompressor: watches both channels, predicts results.
// Depends on lzwd_pkg and the lzwd_in_if / lzwd_out_if interfaces.
// Hands its mismatch count and number of outstanding results to the testbench top.
module lzwd_decode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lzwd_in_if   in_ch,
    lzwd_out_if  out_ch,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lzwd_pkg::*;

    // One decoded result item as the block should present it
    typedef struct packed {
        logic [7:0]         data;
        logic               has_data;
        logic               run_last;
        logic               block_end;
        logic [1:0]         fault;
        logic [COUNT_W-1:0] total;
    } t_decoded;

    // Block walker state
    logic [HDR_W-1:0]    hdr_left;
    logic                stored_mode;
    logic [15:0]         ctrl_word;
    logic [CTRL_W-1:0]   ctrl_left;
    logic                ctrl_hi_pending;
    logic                pair_pending;
    logic [OFF_HI_W-1:0] off_hi;
    logic [LEN_W-1:0]    copy_len;
    logic [7:0]          history [HIST_DEPTH];
    logic [POS_W-1:0]    wr_pos;
    logic [COUNT_W-1:0]  produced;

    t_decoded decoded_q[$];
    t_decoded step_q[$];
    int       mismatch_count;
    int       results_seen;

    initial begin
        o_mismatches   = 0;
        o_outstanding  = 0;
        mismatch_count = 0;
        results_seen   = 0;
        foreach (history[i]) history[i] = 8'h00;
    end

    // Return every piece of walker state but the history to its start of block value
    task automatic restart_block();
        hdr_left        = HEADER_BYTES;
        stored_mode     = 1'b0;
        ctrl_word       = '0;
        ctrl_left       = '0;
        ctrl_hi_pending = 1'b0;
        pair_pending    = 1'b0;
        off_hi          = '0;
        copy_len        = '0;
        wr_pos          = '0;
        produced        = '0;
    endtask

    function automatic t_decoded no_data(input t_fault f);
        t_decoded r;
        r           = '0;
        r.fault     = f;
        r.total     = produced;
        return r;
    endfunction

    // Write a byte to the history, count it and queue its result
    task automatic emit_data(input logic [7:0] v);
        t_decoded r;
        history[wr_pos] = v;
        wr_pos          = wr_pos + 1'b1;
        if (produced != COUNT_MAX) produced = produced + 1'b1;
        r          = '0;
        r.data     = v;
        r.has_data = 1'b1;
        r.total    = produced;
        step_q.push_back(r);
    endtask

    task automatic take_ctrl_bit();
        ctrl_word = ctrl_word >> 1;
        if (ctrl_left != 0) ctrl_left = ctrl_left - 1'b1;
    endtask

    // Work out every result one compressed byte causes
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [11:0]      offset;
        logic [POS_W-1:0] src;
        int               n;
        step_q.delete();
        if (hdr_left != 0) begin
            if (hdr_left == HEADER_BYTES) stored_mode = (b == STORED_FLAG);
            hdr_left = hdr_left - 1'b1;
            step_q.push_back(no_data((last && hdr_left != 0) ? FAULT_EARLY_END : FAULT_NONE));
        end else if (stored_mode) begin
            emit_data(b);
        end else if (ctrl_left == 0) begin
            // Assemble the control word, low byte first
            if (!ctrl_hi_pending) begin
                ctrl_word       = {8'h00, b};
                ctrl_hi_pending = 1'b1;
            end else begin
                ctrl_word       = {b, ctrl_word[7:0]};
                ctrl_left       = CTRL_BITS;
                ctrl_hi_pending = 1'b0;
            end
            step_q.push_back(no_data(last ? FAULT_EARLY_END : FAULT_NONE));
        end else if (ctrl_word[0]) begin
            if (!pair_pending) begin
                off_hi       = b[7:4];
                copy_len     = LEN_W'(b[3:0]) + 1'b1;
                pair_pending = 1'b1;
                step_q.push_back(no_data(last ? FAULT_EARLY_END : FAULT_NONE));
            end else begin
                offset       = {off_hi, b};
                pair_pending = 1'b0;
                take_ctrl_bit();
                if (offset == 0 || COUNT_W'(offset) > produced) begin
                    step_q.push_back(no_data(FAULT_OFFSET));
                end else begin
                    // Copy byte by byte so that overlapping sources repeat
                    src = wr_pos - offset;
                    for (int i = 0; i < copy_len; i++) begin
                        emit_data(history[src]);
                        src = src + 1'b1;
                    end
                end
            end
        end else begin
            take_ctrl_bit();
            emit_data(b);
        end

        n = step_q.size();
        step_q[n-1].run_last = 1'b1;
        if (last) begin
            step_q[n-1].block_end = 1'b1;
            restart_block();
        end
        foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    endtask

    // Print one line per mismatch (the first hundred) and count all of them
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("ERROR: result %0d at %0t: %s", results_seen, $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Predict on each accepted input item, compare each accepted result item
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            restart_block();
            decoded_q.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte, in_ch.block_last);
            if (out_ch.valid && out_ch.ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, out_byte %02h",
                                              out_ch.out_byte));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", out_ch.out_byte, want.data);
                    check_field("has_data", out_ch.has_data, want.has_data);
                    check_field("run_last", out_ch.run_last, want.run_last);
                    check_field("block_end", out_ch.block_end, want.block_end);
                    check_field("fault", out_ch.fault, want.fault);
                    check_field("out_total", out_ch.out_total, want.total);
                end
                results_seen++;
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= decoded_q.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top for lz_window_decompressor_unit: clock, reset, stimulus and verdict.
// Depends on lzwd_pkg, the lzwd interfaces, the block and lzwd_decode_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lzwd_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_AFTER  = 340;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   items_sent = 0;
    bit   quiet = 1'b0;

    logic [7:0] block_bytes[$];

    lzwd_in_if  in_ch ();
    lzwd_out_if out_ch ();

    lz_window_decompressor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzwd_decode_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Consumer side: random stall bursts, none once the run goes quiet
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Offer one compressed byte, with an occasional gap first, and hold until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.block_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_block();
        foreach (block_bytes[i]) send_byte(block_bytes[i], i == block_bytes.size() - 1);
    endtask

    // Hold the input idle until every predicted result has been taken
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Build a mostly well-formed block with random content; sometimes cut it short
    task automatic build_random_block();
        logic [7:0]  hdr0;
        logic [15:0] ctrl;
        logic [11:0] offset;
        int          bits_left;
        int          produced;
        int          n_items;
        int          len;
        int          cut;
        block_bytes.delete();
        if ($urandom_range(0, 5) == 0) begin
            // Stored block
            block_bytes.push_back(STORED_FLAG);
            repeat (3) block_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 24)) block_bytes.push_back(8'($urandom));
        end else begin
            hdr0 = 8'($urandom);
            if (hdr0 == STORED_FLAG) hdr0 = 8'h00;
            block_bytes.push_back(hdr0);
            repeat (3) block_bytes.push_back(8'($urandom));
            n_items   = $urandom_range(0, 40);
            produced  = 0;
            bits_left = 0;
            ctrl      = '0;
            for (int i = 0; i < n_items; i++) begin
                if (bits_left == 0) begin
                    ctrl = 16'($urandom);
                    block_bytes.push_back(ctrl[7:0]);
                    block_bytes.push_back(ctrl[15:8]);
                    bits_left = 16;
                end
                if (ctrl[0]) begin
                    // Match: mostly short copies, some overlapping, a few bad offsets
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                      : $urandom_range(1, 4);
                    if (produced == 0 || $urandom_range(0, 7) == 0) begin
                        offset = ($urandom_range(0, 1) == 0) ? 12'd0
                                 : 12'($urandom_range(produced + 1, 4095));
                    end else if ($urandom_range(0, 2) == 0) begin
                        offset = 12'($urandom_range(1, (produced < 3) ? produced : 3));
                    end else begin
                        offset = 12'($urandom_range(1, produced));
                    end
                    block_bytes.push_back({offset[11:8], 4'(len - 1)});
                    block_bytes.push_back(offset[7:0]);
                    if (offset != 0 && offset <= produced) produced += len;
                end else begin
                    block_bytes.push_back(8'($urandom));
                    produced++;
                end
                ctrl = ctrl >> 1;
                bits_left--;
            end
        end
        // Broken block: end it at an arbitrary byte
        if ($urandom_range(0, 5) == 0 && block_bytes.size() > 1) begin
            cut = $urandom_range(1, block_bytes.size() - 1);
            while (block_bytes.size() > cut) void'(block_bytes.pop_back());
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= 8'h00;
        in_ch.block_last <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Literals at both extremes, overlapping full-length copy, zero and too-far offsets
        block_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h1C, 8'h00, 8'hFF, 8'h00,
                        8'h0F, 8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_block();
        // Stored block passing both extremes straight through
        block_bytes = '{STORED_FLAG, 8'h5A, 8'hA5, 8'h00, 8'h00, 8'hFF};
        send_block();
        // Block ending on its first header byte
        block_bytes = '{8'h00};
        send_block();
        // Block ending cleanly right after the header
        block_bytes = '{8'h02, 8'hFF, 8'h00, 8'hFF};
        send_block();

        // Let everything drain before the random part starts
        wait_drained();

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= QUIET_AFTER) quiet = 1'b1;
            build_random_block();
            send_block();
            if (!quiet && $urandom_range(0, 9) == 0) wait_drained();
        end
        quiet = 1'b1;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
